// ===== sv/grfa_pkg.sv =====
// Shared types and codes for the grid rectangle first-fit allocator.
// No dependencies; used by the allocator top level.
package grfa_pkg;

  // request codes
  localparam logic FUNC_PLACE   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // configuration register indexes and data width
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b1;
  localparam logic [CFG_W-1:0]     GRID_RST      = 5'd16;

  // request beat
  typedef struct packed {
    logic       func;
    logic [4:0] plug_height;
    logic [4:0] plug_width;
    logic [3:0] rel_row;
    logic [3:0] rel_col;
  } req_t;

  // result beat
  typedef struct packed {
    logic       found;
    logic [3:0] corner_row;
    logic [3:0] corner_col;
  } rsp_t;

endpackage

// ===== sv/grfa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the occupancy rows of the allocator.
module grfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/grfa_fit.sv =====
// Column fit finder: marks every start column where a run of free cells fits
// in the OR of the candidate rows, registers it and picks the lowest one.
// No dependencies; instanced by the allocator top level.
module grfa_fit #(
  parameter int MAX_COLS = 16
) (
  input  logic                clk,
  input  logic                load,
  input  logic [MAX_COLS-1:0] acc,
  input  logic [4:0]          wid,
  input  logic [($clog2(MAX_COLS+1) > 5 ? $clog2(MAX_COLS+1) : 5):0] cols,
  output logic                hit,
  output logic [($clog2(MAX_COLS+1) > 5 ? $clog2(MAX_COLS+1) : 5):0] col
);

  localparam int CC_W = ($clog2(MAX_COLS+1) > 5 ? $clog2(MAX_COLS+1) : 5) + 1;

  logic [MAX_COLS-1:0] wmask;
  logic [MAX_COLS-1:0] fit;
  logic [MAX_COLS-1:0] fit_r;
  logic [MAX_COLS-1:0] low;
  logic [CC_W-1:0]     wid_x;

  assign wid_x = CC_W'(wid);

  // run mask of the rectangle width, then one fit flag per start column
  always_comb begin
    logic [MAX_COLS-1:0] span;
    for (int j = 0; j < MAX_COLS; j++) begin
      wmask[j] = CC_W'(j) < wid_x;
    end
    for (int c = 0; c < MAX_COLS; c++) begin
      span   = wmask << c;
      fit[c] = ((CC_W'(c) + wid_x) <= cols) && ((acc & span) == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fit_r <= fit;
    end
  end

  // lowest set flag, encoded
  assign low = fit_r & (~fit_r + MAX_COLS'(1));

  always_comb begin
    col = '0;
    for (int j = 0; j < MAX_COLS; j++) begin
      if (low[j]) begin
        col = col | CC_W'(j);
      end
    end
  end

  assign hit = |fit_r;

endmodule

// ===== sv/grid_rectangle_first_fit_allocator.sv =====
// Grid rectangle first-fit allocator: top level with control sequencer.
// Depends on grfa_pkg, grfa_ram (occupancy rows) and grfa_fit (column search).
//
// Usage:
//  - in_valid/in_ready/in_data carry one request beat: place (find the first
//    free plug_height x plug_width rectangle in row-major order and mark it)
//    or release (clear the named rectangle, clipped to the storage).
//  - out_valid/out_ready/out_data carry exactly one result beat per request:
//    found and corner for a place, found = 0 and the echoed corner for a
//    release, all zero when nothing fits.
//  - cfg_we/cfg_index/cfg_wdata write grid_rows and grid_cols; write them
//    only while no request is in flight.
//  - one request at a time: a release clears the rows it names; a place
//    tries start rows in turn (the band is read from the occupancy RAM one
//    row per cycle), then writes the rows back and loads the result; a size
//    that cannot fit goes straight to the result. in_ready comes back
//    together with out_valid.
//  - after reset every cell reads free (one valid bit per RAM row) and both
//    grid registers are 16; no clearing pass is needed.
//  - the result sits in an output register; a new request is accepted while
//    it waits, and a later result waits until the receiver takes it.
module grid_rectangle_first_fit_allocator #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  grfa_pkg::req_t                  in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output grfa_pkg::rsp_t                  out_data,
  input  logic                            cfg_we,
  input  logic [grfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [grfa_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int RA_W = $clog2(MAX_ROWS);
  localparam int RC_W = ($clog2(MAX_ROWS+1) > 5 ? $clog2(MAX_ROWS+1) : 5) + 1;
  localparam int CC_W = ($clog2(MAX_COLS+1) > 5 ? $clog2(MAX_COLS+1) : 5) + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_EVAL = 3'd2;
  localparam logic [2:0] ST_PICK = 3'd3;
  localparam logic [2:0] ST_MARK = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]                  state_r, state_nxt;
  logic [grfa_pkg::CFG_W-1:0]  grid_rows_r, grid_cols_r;
  logic [4:0]                  h_r, h_nxt;
  logic [4:0]                  w_r, w_nxt;
  logic [RC_W-1:0]             r_r, r_nxt;
  logic [RC_W-1:0]             cur_r, cur_nxt;
  logic [RC_W-1:0]             end_r, end_nxt;
  logic [MAX_COLS-1:0]         acc_r, acc_nxt;
  logic [MAX_COLS-1:0]         mask_r, mask_nxt;
  logic                        op_set_r, op_set_nxt;
  logic                        pend_r;
  logic                        pend_vld_r;
  logic [RA_W-1:0]             pend_addr_r;
  logic [MAX_ROWS-1:0]         row_valid_r;
  grfa_pkg::rsp_t              res_r, res_nxt;
  logic                        out_valid_r, out_valid_nxt;
  grfa_pkg::rsp_t              out_data_r, out_data_nxt;

  logic [RC_W-1:0]     rows_use;
  logic [CC_W-1:0]     cols_use;
  logic [RC_W-1:0]     rel_end_raw, rel_end;
  logic [RC_W-1:0]     r_inc, r_inc_end;
  logic [CC_W-1:0]     span_lo, span_hi;
  logic [MAX_COLS-1:0] span_m;
  logic                issue;
  logic                ram_we, ram_re;
  logic [RA_W-1:0]     ram_waddr, ram_raddr;
  logic [MAX_COLS-1:0] ram_wdata, ram_rdata, rdat;
  logic                fit_load, fit_hit;
  logic [CC_W-1:0]     fit_col;
  logic                no_fit;

  // occupancy storage
  grfa_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // column search over the OR of a band of rows
  grfa_fit #(
    .MAX_COLS (MAX_COLS)
  ) u_fit (
    .clk  (clk),
    .load (fit_load),
    .acc  (acc_r),
    .wid  (w_r),
    .cols (cols_use),
    .hit  (fit_hit),
    .col  (fit_col)
  );

  // used grid size, saturated at the storage
  assign rows_use = (RC_W'(grid_rows_r) > RC_W'(MAX_ROWS)) ? RC_W'(MAX_ROWS)
                                                           : RC_W'(grid_rows_r);
  assign cols_use = (CC_W'(grid_cols_r) > CC_W'(MAX_COLS)) ? CC_W'(MAX_COLS)
                                                           : CC_W'(grid_cols_r);

  // release row range, clipped to the storage
  assign rel_end_raw = RC_W'(in_data.rel_row) + RC_W'(in_data.plug_height);
  assign rel_end     = (rel_end_raw > RC_W'(MAX_ROWS)) ? RC_W'(MAX_ROWS) : rel_end_raw;

  // next start row of the scan
  assign r_inc     = r_r + RC_W'(1);
  assign r_inc_end = r_inc + RC_W'(h_r);

  // column span mask: placed corner in PICK, release request otherwise
  always_comb begin
    if (state_r == ST_PICK) begin
      span_lo = fit_col;
      span_hi = fit_col + CC_W'(w_r);
    end else begin
      span_lo = CC_W'(in_data.rel_col);
      span_hi = CC_W'(in_data.rel_col) + CC_W'(in_data.plug_width);
    end
    for (int j = 0; j < MAX_COLS; j++) begin
      span_m[j] = (CC_W'(j) >= span_lo) && (CC_W'(j) < span_hi);
    end
  end

  // place request that cannot fit anywhere
  assign no_fit = (in_data.plug_height == '0) || (in_data.plug_width == '0) ||
                  (RC_W'(in_data.plug_height) > rows_use) ||
                  (CC_W'(in_data.plug_width) > cols_use);

  // RAM access: reads walk cur_r, writes trail one row behind
  assign issue     = ((state_r == ST_SCAN) || (state_r == ST_MARK)) && (cur_r < end_r);
  assign ram_re    = issue;
  assign ram_raddr = cur_r[RA_W-1:0];
  assign rdat      = pend_vld_r ? ram_rdata : '0;
  assign ram_we    = (state_r == ST_MARK) && pend_r;
  assign ram_waddr = pend_addr_r;
  assign ram_wdata = op_set_r ? (rdat | mask_r) : (rdat & ~mask_r);
  assign fit_load  = (state_r == ST_EVAL);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    h_nxt         = h_r;
    w_nxt         = w_r;
    r_nxt         = r_r;
    cur_nxt       = issue ? cur_r + RC_W'(1) : cur_r;
    end_nxt       = end_r;
    acc_nxt       = acc_r;
    mask_nxt      = mask_r;
    op_set_nxt    = op_set_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          h_nxt = in_data.plug_height;
          w_nxt = in_data.plug_width;
          if (in_data.func == grfa_pkg::FUNC_RELEASE) begin
            op_set_nxt         = 1'b0;
            cur_nxt            = RC_W'(in_data.rel_row);
            end_nxt            = rel_end;
            mask_nxt           = span_m;
            res_nxt.found      = 1'b0;
            res_nxt.corner_row = in_data.rel_row;
            res_nxt.corner_col = in_data.rel_col;
            state_nxt          = ST_MARK;
          end else begin
            res_nxt = '0;
            r_nxt   = '0;
            cur_nxt = '0;
            end_nxt = RC_W'(in_data.plug_height);
            acc_nxt = '0;
            state_nxt = no_fit ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (pend_r) begin
          acc_nxt = acc_r | rdat;
        end
        if (!issue) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (fit_hit) begin
          op_set_nxt         = 1'b1;
          mask_nxt           = span_m;
          cur_nxt            = r_r;
          end_nxt            = r_r + RC_W'(h_r);
          res_nxt.found      = 1'b1;
          res_nxt.corner_row = r_r[3:0];
          res_nxt.corner_col = fit_col[3:0];
          state_nxt          = ST_MARK;
        end else if (r_inc_end > rows_use) begin
          state_nxt = ST_DONE;
        end else begin
          r_nxt     = r_inc;
          cur_nxt   = r_inc;
          end_nxt   = r_inc_end;
          acc_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_MARK: begin
        if (!issue && !pend_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      row_valid_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= issue;
      if (ram_we) begin
        row_valid_r[ram_waddr] <= 1'b1;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= grfa_pkg::GRID_RST;
      grid_cols_r <= grfa_pkg::GRID_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        grfa_pkg::CFG_GRID_ROWS: grid_rows_r <= cfg_wdata;
        grfa_pkg::CFG_GRID_COLS: grid_cols_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    h_r        <= h_nxt;
    w_r        <= w_nxt;
    r_r        <= r_nxt;
    cur_r      <= cur_nxt;
    end_r      <= end_nxt;
    acc_r      <= acc_nxt;
    mask_r     <= mask_nxt;
    op_set_r   <= op_set_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    if (issue) begin
      pend_addr_r <= cur_r[RA_W-1:0];
      pend_vld_r  <= row_valid_r[cur_r[RA_W-1:0]];
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // writes only come from the mark walk and never hit the row being read
  a_write_in_mark: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_MARK))
    else $error("occupancy write outside mark walk");

  a_no_same_row: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write of the same row in one cycle");

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_r)
    else $error("read still in flight while accepting requests");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside the done state");

endmodule
